[hw/rtl/rsa_pkg.sv]
package rsa_pkg;

	// Table geometry
	localparam int NUM_SLOTS = 32;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int TREE_N    = 1 << SLOT_W;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SRCH_W    = $clog2(SLOT_W + 1);

	// Field widths
	localparam int OP_W     = 2;
	localparam int NAME_W   = 16;
	localparam int SCOPE_W  = 8;
	localparam int STAMP_W  = 32;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 6;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FAIL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_VAR  = 2'd0,
		OP_TEMP = 2'd1,
		OP_REL  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// Final action of a request
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_FOUND   = 3'd1,
		ACT_ALLOC   = 3'd2,
		ACT_EVICT   = 3'd3,
		ACT_RELEASE = 3'd4,
		ACT_FAIL    = 3'd5
	} act_t;

	typedef struct packed {
		logic capture;
		logic look;
		logic reduce;
		act_t act;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic full;
		logic victim_ok;
	} stat_t;

endpackage

[hw/rtl/rsa_ctrl.sv]
module rsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rsa_pkg::stat_t stat,
	output rsa_pkg::cmd_t  cmd
);
	import rsa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOK   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_SEARCH = 5'b01000,
		S_EVICT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [SRCH_W-1:0] cnt_q, cnt_d;

	assign busy = (state_q != S_IDLE);

	// Sequence one request: capture, look up, decide, search for victim if full
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.capture = 1'b0;
		cmd.look    = 1'b0;
		cmd.reduce  = 1'b0;
		cmd.act     = ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				case (stat.op)
					OP_REL:  cmd.act = ACT_RELEASE;
					OP_NONE: cmd.act = ACT_FAIL;
					default: begin
						if (stat.op == OP_VAR && stat.hit) begin
							cmd.act = ACT_FOUND;
						end else if (!stat.full) begin
							cmd.act = ACT_ALLOC;
						end else begin
							cnt_d   = '0;
							state_d = S_SEARCH;
						end
					end
				endcase
			end
			S_SEARCH: begin
				cmd.reduce = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == SRCH_W'(SLOT_W - 1)) begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				cmd.act = stat.victim_ok ? ACT_EVICT : ACT_FAIL;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[hw/rtl/rsa_dpath.sv]
module rsa_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsa_pkg::cmd_t                  cmd,
	output rsa_pkg::stat_t                 stat,
	input  logic [rsa_pkg::OP_W-1:0]       operation,
	input  logic [rsa_pkg::NAME_W-1:0]     name_id,
	input  logic [rsa_pkg::SCOPE_W-1:0]    scope_id,
	output logic                           done,
	output logic [rsa_pkg::IDX_W-1:0]      slot_index,
	output logic [rsa_pkg::STATUS_W-1:0]   status,
	output logic [rsa_pkg::IDX_W-1:0]      evicted_index,
	output logic [rsa_pkg::FREE_W-1:0]     free_count
);
	import rsa_pkg::*;

	// Slot table
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NAME_W-1:0]    name_q  [NUM_SLOTS];
	logic [SCOPE_W-1:0]   scope_q [NUM_SLOTS];
	logic [STAMP_W-1:0]   stamp_q [NUM_SLOTS];
	logic [STAMP_W-1:0]   next_stamp_q;
	logic [CNT_W-1:0]     pin_cnt_q;
	logic [CNT_W-1:0]     temp_cnt_q;

	// Request
	op_t                  op_q;
	logic [NAME_W-1:0]    req_name_q;
	logic [SCOPE_W-1:0]   req_scope_q;

	// Lookup results
	logic                 hit_q;
	logic [SLOT_W-1:0]    hit_idx_q;
	logic [SLOT_W-1:0]    free_idx_q;
	logic                 full_q;

	// Minimum-stamp tree nodes, reduced in place one level per cycle
	logic                 node_vld_q   [TREE_N];
	logic [STAMP_W-1:0]   node_stamp_q [TREE_N];
	logic [SLOT_W-1:0]    node_idx_q   [TREE_N];

	// Result register
	logic                 done_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [IDX_W-1:0]     res_evict_q;
	logic [FREE_W-1:0]    res_free_q;

	logic                 hit_c;
	logic [SLOT_W-1:0]    hit_idx_c;
	logic [SLOT_W-1:0]    free_idx_c;
	logic                 is_temp;
	logic [SLOT_W-1:0]    slot_sel;
	logic [CNT_W-1:0]     pin_cnt_d;
	logic [CNT_W-1:0]     temp_cnt_d;
	logic [CNT_W-1:0]     free_c;
	logic                 write_slot;

	assign stat.op        = op_q;
	assign stat.hit       = hit_q;
	assign stat.full      = full_q;
	assign stat.victim_ok = node_vld_q[0];

	assign is_temp    = (op_q == OP_TEMP);
	assign slot_sel   = (cmd.act == ACT_EVICT) ? node_idx_q[0] : free_idx_q;
	assign write_slot = (cmd.act == ACT_ALLOC) || (cmd.act == ACT_EVICT);

	// Match pinned slots by key and find the lowest free slot
	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && stamp_q[i] == '0 && name_q[i] == req_name_q &&
			    scope_q[i] == req_scope_q) begin
				hit_c     = 1'b1;
				hit_idx_c = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx_c = SLOT_W'(i);
			end
		end
	end

	// Update pinned and temporary counts for the final action
	always_comb begin
		pin_cnt_d  = pin_cnt_q;
		temp_cnt_d = temp_cnt_q;
		case (cmd.act)
			ACT_ALLOC: begin
				if (is_temp) begin
					temp_cnt_d = temp_cnt_q + 1'b1;
				end else begin
					pin_cnt_d = pin_cnt_q + 1'b1;
				end
			end
			ACT_EVICT: begin
				if (!is_temp) begin
					temp_cnt_d = temp_cnt_q - 1'b1;
					pin_cnt_d  = pin_cnt_q + 1'b1;
				end
			end
			ACT_RELEASE: pin_cnt_d = '0;
			default: ;
		endcase
		free_c = CNT_W'(NUM_SLOTS) - (pin_cnt_d + temp_cnt_d);
	end

	// Capture request, latch lookup, reduce tree, write slot fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= op_t'(operation);
			req_name_q  <= name_id;
			req_scope_q <= scope_id;
		end
		if (cmd.look) begin
			hit_q      <= hit_c;
			hit_idx_q  <= hit_idx_c;
			free_idx_q <= free_idx_c;
			full_q     <= &valid_q;
			for (int i = 0; i < TREE_N; i++) begin
				node_idx_q[i] <= SLOT_W'(i);
				if (i < NUM_SLOTS) begin
					node_vld_q[i]   <= valid_q[i] && stamp_q[i] != '0;
					node_stamp_q[i] <= stamp_q[i];
				end else begin
					node_vld_q[i]   <= 1'b0;
					node_stamp_q[i] <= '0;
				end
			end
		end else if (cmd.reduce) begin
			// Left node holds lower indices, so it wins ties
			for (int i = 0; i < TREE_N / 2; i++) begin
				if (node_vld_q[2*i+1] &&
				    (!node_vld_q[2*i] || node_stamp_q[2*i+1] < node_stamp_q[2*i])) begin
					node_vld_q[i]   <= 1'b1;
					node_stamp_q[i] <= node_stamp_q[2*i+1];
					node_idx_q[i]   <= node_idx_q[2*i+1];
				end else begin
					node_vld_q[i]   <= node_vld_q[2*i];
					node_stamp_q[i] <= node_stamp_q[2*i];
					node_idx_q[i]   <= node_idx_q[2*i];
				end
			end
		end
		if (write_slot) begin
			name_q[slot_sel]  <= is_temp ? '0 : req_name_q;
			scope_q[slot_sel] <= req_scope_q;
			stamp_q[slot_sel] <= is_temp ? next_stamp_q : '0;
		end
	end

	// Hold table control state and emit result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			next_stamp_q <= STAMP_W'(1);
			pin_cnt_q    <= '0;
			temp_cnt_q   <= '0;
			done_q       <= 1'b0;
			res_slot_q   <= '0;
			res_status_q <= ST_FOUND;
			res_evict_q  <= '0;
			res_free_q   <= '0;
		end else begin
			done_q <= (cmd.act != ACT_NONE);
			if (cmd.act != ACT_NONE) begin
				pin_cnt_q   <= pin_cnt_d;
				temp_cnt_q  <= temp_cnt_d;
				res_free_q  <= FREE_W'(free_c);
				res_slot_q  <= '0;
				res_evict_q <= '0;
			end
			if (write_slot) begin
				valid_q[slot_sel] <= 1'b1;
				if (next_stamp_q != '1) begin
					next_stamp_q <= next_stamp_q + 1'b1;
				end
				res_slot_q <= IDX_W'(slot_sel);
			end
			case (cmd.act)
				ACT_FOUND: begin
					res_status_q <= ST_FOUND;
					res_slot_q   <= IDX_W'(hit_idx_q);
				end
				ACT_ALLOC: res_status_q <= ST_ALLOC;
				ACT_EVICT: begin
					res_status_q <= ST_EVICT;
					res_evict_q  <= IDX_W'(node_idx_q[0]);
				end
				ACT_RELEASE: begin
					res_status_q <= ST_RELEASED;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (valid_q[i] && stamp_q[i] == '0) begin
							valid_q[i] <= 1'b0;
						end
					end
				end
				ACT_FAIL: res_status_q <= ST_FAIL;
				default: ;
			endcase
		end
	end

	assign done          = done_q;
	assign slot_index    = res_slot_q;
	assign status        = res_status_q;
	assign evicted_index = res_evict_q;
	assign free_count    = res_free_q;

endmodule

[hw/rtl/register_slot_allocator.sv]
// Register slot allocator: a table of slots keyed by variable id and scope id.
// A request is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done high and must be taken
// then, since the receiver cannot stall the block. A lookup hit, an allocation
// into a free slot, a release or an unused operation code is settled after the
// capture and lookup states. An allocation (variable miss or temporary) that
// finds the table full also passes through a search of the minimum-stamp tree,
// reduced one level a cycle, before it evicts or fails.
module register_slot_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rsa_pkg::OP_W-1:0]       operation,
	input  logic [rsa_pkg::NAME_W-1:0]     name_id,
	input  logic [rsa_pkg::SCOPE_W-1:0]    scope_id,
	output logic                           done,
	output logic [rsa_pkg::IDX_W-1:0]      slot_index,
	output logic [rsa_pkg::STATUS_W-1:0]   status,
	output logic [rsa_pkg::IDX_W-1:0]      evicted_index,
	output logic [rsa_pkg::FREE_W-1:0]     free_count
);
	import rsa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	rsa_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.name_id       (name_id),
		.scope_id      (scope_id),
		.done          (done),
		.slot_index    (slot_index),
		.status        (status),
		.evicted_index (evicted_index),
		.free_count    (free_count)
	);

	// A taken request keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request accept");

	// A result follows only a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// Evicted slot reported only on eviction
	a_evict_field: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_EVICT |-> evicted_index == '0)
		else $error("evicted index set without eviction");

	// Release and failure carry slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_RELEASED || status == ST_FAIL) |-> slot_index == '0)
		else $error("slot index set on release or failure");

endmodule

[tb/tb_register_slot_allocator.sv]
`timescale 1ns / 100ps

import rsa_pkg::*;

// One reply of the allocator, field for field
typedef struct packed {
	logic [IDX_W-1:0]    slot_idx;
	logic [STATUS_W-1:0] code;
	logic [IDX_W-1:0]    victim_idx;
	logic [FREE_W-1:0]   free_slots;
} slot_reply_t;

class slot_scoreboard;
	bit                 taken       [NUM_SLOTS];
	bit [NAME_W-1:0]    owner_name  [NUM_SLOTS];
	bit [SCOPE_W-1:0]   owner_scope [NUM_SLOTS];
	bit [STAMP_W-1:0]   age         [NUM_SLOTS];
	bit [STAMP_W-1:0]   next_age;
	int unsigned        occupied;
	slot_reply_t        expected_replies[$];
	int                 errors;

	function new();
		foreach (taken[i]) begin
			taken[i] = 1'b0;
			owner_name[i] = '0;
			owner_scope[i] = '0;
			age[i] = '0;
		end
		next_age = 1;
		occupied = 0;
		errors = 0;
	endfunction

	function slot_reply_t make_reply(int slot_i, logic [STATUS_W-1:0] code, int victim);
		slot_reply_t r;
		r.slot_idx = IDX_W'(slot_i);
		r.code = code;
		r.victim_idx = IDX_W'(victim);
		r.free_slots = FREE_W'(NUM_SLOTS - occupied);
		return r;
	endfunction

	// Take the lowest free slot, evicting the oldest temporary when the table is full
	function slot_reply_t allocate(logic [NAME_W-1:0] nm, logic [SCOPE_W-1:0] sc, bit temp);
		int victim;
		int slot_i;
		logic [STATUS_W-1:0] code;
		victim = -1;
		slot_i = -1;
		code = ST_ALLOC;
		if (occupied >= NUM_SLOTS) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (taken[i] && age[i] != 0 && (victim < 0 || age[i] < age[victim]))
					victim = i;
			end
			if (victim < 0)
				return make_reply(0, ST_FAIL, 0);
			taken[victim] = 1'b0;
			age[victim] = '0;
			occupied--;
			code = ST_EVICT;
		end
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!taken[i])
				slot_i = i;
		end
		if (slot_i < 0)
			return make_reply(0, ST_FAIL, 0);
		taken[slot_i] = 1'b1;
		owner_name[slot_i] = temp ? '0 : nm;
		owner_scope[slot_i] = sc;
		age[slot_i] = temp ? next_age : '0;
		// saturate the age counter
		if (next_age != '1)
			next_age++;
		occupied++;
		return make_reply(slot_i, code, (victim < 0) ? 0 : victim);
	endfunction

	// Predict the reply to an accepted request and queue it
	function void note_request(op_t op, logic [NAME_W-1:0] nm, logic [SCOPE_W-1:0] sc);
		slot_reply_t r;
		int hit;
		hit = -1;
		case (op)
			OP_VAR: begin
				// match only pinned variables, lowest slot first
				for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
					if (taken[i] && age[i] == 0 && owner_name[i] == nm && owner_scope[i] == sc)
						hit = i;
				end
				if (hit >= 0)
					r = make_reply(hit, ST_FOUND, 0);
				else
					r = allocate(nm, sc, 1'b0);
			end
			OP_TEMP: r = allocate('0, sc, 1'b1);
			OP_REL: begin
				// drop pinned variables, keep temporaries
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (taken[i] && age[i] == 0) begin
						taken[i] = 1'b0;
						owner_name[i] = '0;
						owner_scope[i] = '0;
						occupied--;
					end
				end
				r = make_reply(0, ST_RELEASED, 0);
			end
			default: r = make_reply(0, ST_FAIL, 0);
		endcase
		expected_replies.push_back(r);
	endfunction

	// Compare a reply against the oldest prediction
	function void check_result(slot_reply_t got);
		slot_reply_t want;
		if (expected_replies.size() == 0) begin
			$error("reply with no request outstanding: slot_index %0d status %0d",
				got.slot_idx, got.code);
			errors++;
			return;
		end
		want = expected_replies.pop_front();
		if (got.slot_idx !== want.slot_idx) begin
			$error("slot_index: expected %0d, actual %0d", want.slot_idx, got.slot_idx);
			errors++;
		end
		if (got.code !== want.code) begin
			$error("status: expected %0d, actual %0d", want.code, got.code);
			errors++;
		end
		if (got.victim_idx !== want.victim_idx) begin
			$error("evicted_index: expected %0d, actual %0d", want.victim_idx, got.victim_idx);
			errors++;
		end
		if (got.free_slots !== want.free_slots) begin
			$error("free_count: expected %0d, actual %0d", want.free_slots, got.free_slots);
			errors++;
		end
	endfunction
endclass

module tb_register_slot_allocator;

	localparam int STALL_LIMIT  = 2000;
	localparam int QUIET_CYCLES = 20;
	localparam int RANDOM_ITEMS = 600;
	localparam int PAUSE_EVERY  = 120;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OP_W-1:0]     operation = '0;
	logic [NAME_W-1:0]   name_id = '0;
	logic [SCOPE_W-1:0]  scope_id = '0;
	logic                busy;
	logic                done;
	logic [IDX_W-1:0]    slot_index;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    evicted_index;
	logic [FREE_W-1:0]   free_count;

	slot_scoreboard sb = new();
	bit             gaps_on = 1'b0;
	int             sent = 0;
	int             stall_cycles;

	register_slot_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.name_id       (name_id),
		.scope_id      (scope_id),
		.done          (done),
		.slot_index    (slot_index),
		.status        (status),
		.evicted_index (evicted_index),
		.free_count    (free_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check every reply in the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(slot_reply_t'{slot_index, status, evicted_index, free_count});
	end

	// Abort when neither a request nor a reply moves for too long
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$error("no request or reply for %0d cycles", STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Hold a request until the block takes it; idle now and then beforehand
	task automatic send_request(op_t op, logic [NAME_W-1:0] nm, logic [SCOPE_W-1:0] sc);
		if (gaps_on && $urandom_range(99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		name_id <= nm;
		scope_id <= sc;
		do @(posedge clk); while (busy);
		sb.note_request(op, nm, sc);
		sent++;
	endtask

	// Stop sending until every reply is in
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.expected_replies.size() != 0) @(posedge clk);
	endtask

	// Release, pin a full table of distinct variables, then ask for more
	task automatic fill_table();
		logic [NAME_W-1:0]  base;
		logic [SCOPE_W-1:0] sc;
		base = NAME_W'($urandom);
		sc = SCOPE_W'($urandom);
		send_request(OP_REL, NAME_W'($urandom), SCOPE_W'($urandom));
		for (int i = 0; i < NUM_SLOTS + 2; i++)
			send_request(OP_VAR, base + NAME_W'(i), sc);
		send_request(OP_TEMP, NAME_W'($urandom), sc);
		send_request(OP_VAR, base + NAME_W'($urandom_range(NUM_SLOTS - 1)), sc);
	endtask

	initial begin
		int                 pick;
		int                 stop_at;
		int                 next_pause;
		logic [NAME_W-1:0]  nm;
		logic [SCOPE_W-1:0] sc;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, every operation, temporaries never matching a lookup
		send_request(OP_VAR,  16'h0000, 8'h00);
		send_request(OP_VAR,  16'h0000, 8'h00);
		send_request(OP_VAR,  16'hFFFF, 8'hFF);
		send_request(OP_VAR,  16'hFFFF, 8'h00);
		send_request(OP_TEMP, 16'hFFFF, 8'hFF);
		send_request(OP_VAR,  16'h0000, 8'hFF);
		send_request(OP_NONE, 16'hFFFF, 8'hFF);
		send_request(OP_TEMP, 16'h0000, 8'h00);
		send_request(OP_REL,  16'h0000, 8'h00);
		send_request(OP_VAR,  16'hFFFF, 8'hFF);
		send_request(OP_VAR,  16'hA5A5, 8'h5A);
		send_request(OP_VAR,  16'h5A5A, 8'hA5);
		send_request(OP_VAR,  16'hA5A5, 8'h5A);
		send_request(OP_NONE, 16'h0000, 8'h00);
		send_request(OP_REL,  16'hFFFF, 8'hFF);
		wait_drained();

		// Full table with nothing to evict, then random traffic
		gaps_on = 1'b1;
		fill_table();
		stop_at = sent + RANDOM_ITEMS;
		next_pause = sent + PAUSE_EVERY;
		while (sent < stop_at) begin
			// keep one long stretch free of gaps
			gaps_on = !(sent >= 300 && sent < 450);
			if (sent >= next_pause) begin
				wait_drained();
				next_pause += PAUSE_EVERY;
			end
			pick = $urandom_range(99);
			if (pick < 2) begin
				fill_table();
			end else if (pick < 50) begin
				// mostly a small pool of keys so lookups hit
				if ($urandom_range(3) != 0) begin
					nm = NAME_W'($urandom_range(15));
					sc = SCOPE_W'($urandom_range(3));
				end else begin
					nm = NAME_W'($urandom);
					sc = SCOPE_W'($urandom);
				end
				send_request(OP_VAR, nm, sc);
			end else if (pick < 84) begin
				send_request(OP_TEMP, NAME_W'($urandom), SCOPE_W'($urandom));
			end else if (pick < 94) begin
				send_request(OP_REL, NAME_W'($urandom), SCOPE_W'($urandom));
			end else begin
				send_request(OP_NONE, NAME_W'($urandom), SCOPE_W'($urandom));
			end
		end

		wait_drained();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_replies.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[register_slot_allocator.f]
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_ctrl.sv
hw/rtl/rsa_dpath.sv
hw/rtl/register_slot_allocator.sv
tb/tb_register_slot_allocator.sv
